// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the barometer compensation block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package bpc_pkg;

  localparam int unsigned CFG_W        = 48;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned RAW_W        = 20;
  localparam int unsigned TEMP_W       = 21;
  localparam int unsigned PRESS_W      = 32;
  localparam int unsigned FINE_W       = 25;
  localparam int unsigned ADC_BITS_DEF = 20;
  localparam int unsigned QUOT_BITS    = 40;
  localparam int unsigned DM_W         = 48;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned IN_TDATA_W   = 24;
  localparam int unsigned OUT_TDATA_W  = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MID  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 2'd3;

  localparam logic MODE_TEMP  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  typedef enum logic [4:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_T1,
    STEP_T2,
    STEP_T3,
    STEP_P1,
    STEP_P2,
    STEP_P3,
    STEP_P4,
    STEP_P5,
    STEP_ZERO,
    STEP_DIV_INIT,
    STEP_DIV,
    STEP_P7,
    STEP_P8,
    STEP_P9,
    STEP_P10
  } step_e;

  typedef struct packed {
    step_e step;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_datapath.sv =====
// Datapath: trim word decode, staged products, serial quotient and clamps.
// Depends on bpc_pkg; sequenced one step per cycle by bpc_ctrl.
`default_nettype none

module bpc_datapath #(
  parameter int unsigned AdcBits = bpc_pkg::ADC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bpc_pkg::step_e               step_i,
  input  wire logic                         mode_i,
  input  wire logic [bpc_pkg::RAW_W-1:0]    raw_i,
  input  wire logic [bpc_pkg::CFG_W-1:0]    temp_trim_i,
  input  wire logic [bpc_pkg::CFG_W-1:0]    press_low_i,
  input  wire logic [bpc_pkg::CFG_W-1:0]    press_mid_i,
  input  wire logic [bpc_pkg::CFG_W-1:0]    press_high_i,
  output bpc_pkg::dp_status_t               status_o,
  output logic                              res_kind_o,
  output logic signed [bpc_pkg::TEMP_W-1:0] res_temp_o,
  output logic [bpc_pkg::PRESS_W-1:0]       res_press_o,
  output logic                              res_valid_o
);
  import bpc_pkg::*;

  localparam logic [RAW_W-1:0] AdcMask = {RAW_W{1'b1}} << (RAW_W - AdcBits);

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [16:0] p1s;

  assign t1  = temp_trim_i[15:0];
  assign t2  = $signed(temp_trim_i[31:16]);
  assign t3  = $signed(temp_trim_i[47:32]);
  assign p1  = press_low_i[15:0];
  assign p1s = $signed({1'b0, p1});
  assign p2  = $signed(press_low_i[31:16]);
  assign p3  = $signed(press_low_i[47:32]);
  assign p4  = $signed(press_mid_i[15:0]);
  assign p5  = $signed(press_mid_i[31:16]);
  assign p6  = $signed(press_mid_i[47:32]);
  assign p7  = $signed(press_high_i[15:0]);
  assign p8  = $signed(press_high_i[31:16]);
  assign p9  = $signed(press_high_i[47:32]);

  logic [RAW_W-1:0]        adc_q;
  logic                    kind_q;
  logic signed [FINE_W-1:0] fine_q, fine_d;

  logic signed [35:0] prod_a_q, dd_q;
  logic signed [37:0] b_q;
  logic signed [51:0] vv_q;
  logic signed [41:0] vp5_q, vp2_q;
  logic signed [67:0] vvp6_q, vvp3_q, e2_q, acc_q, x_q;
  logic signed [51:0] div_q;
  logic [75:0]        n_q;
  logic               neg_q, sat_q;
  logic [DM_W-1:0]    dm_q, rem_q;
  logic [QUOT_BITS-1:0] nq_q;
  logic signed [38:0] qs_q;
  logic signed [52:0] c9sq_q;
  logic signed [55:0] c8_q;
  logic signed [43:0] c9_q;

  logic signed [18:0] a_pre;
  logic signed [17:0] diff;
  logic signed [37:0] tf_w;
  logic signed [28:0] t5_w;
  logic signed [25:0] v;
  logic signed [84:0] accp1;
  logic signed [51:0] div_abs;
  logic [67:0]        x_abs;
  logic [35:0]        n_hi;
  logic [DM_W:0]      rem2;
  logic               qbit;
  logic signed [25:0] c9a;
  logic signed [68:0] c9p;
  logic signed [45:0] sum_w;
  logic signed [46:0] pr_w;
  logic [PRESS_W-1:0] pr_sat;
  logic [QUOT_BITS:0] q_neg;

  always_comb begin
    a_pre   = $signed({2'b00, adc_q[RAW_W-1:3]}) - $signed({2'b00, t1, 1'b0});
    diff    = $signed({2'b00, adc_q[RAW_W-1:4]}) - $signed({2'b00, t1});
    tf_w    = (prod_a_q >>> 11) + (b_q >>> 14);
    fine_d  = tf_w[FINE_W-1:0];
    t5_w    = (29'(fine_d) <<< 2) + 29'(fine_d) + 29'sd128;
    v       = 26'(fine_q) - 26'sd128000;
    accp1   = acc_q * p1s;
    div_abs = div_q[51] ? -div_q : div_q;
    x_abs   = x_q[67] ? 68'(-x_q) : 68'(x_q);
    n_hi    = n_q[75:QUOT_BITS];
    rem2    = {rem_q, nq_q[QUOT_BITS-1]};
    qbit    = rem2 >= {1'b0, dm_q};
    q_neg   = -{1'b0, nq_q};
    c9a     = qs_q[38:13];
    c9p     = c9sq_q * p9;
    sum_w   = 46'(qs_q) + 46'(c9_q) + 46'(c8_q >>> 19);
    pr_w    = 47'(sum_w >>> 8) + (47'(p7) <<< 4);
    if (pr_w < 0) begin
      pr_sat = '0;
    end else if (pr_w > 47'sh0_FFFF_FFFF) begin
      pr_sat = '1;
    end else begin
      pr_sat = pr_w[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_q <= '0;
    end else if (step_i == STEP_T3) begin
      fine_q <= fine_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (step_i)
      STEP_LOAD: begin
        adc_q  <= raw_i & AdcMask;
        kind_q <= mode_i;
      end
      STEP_T1: begin
        prod_a_q <= a_pre * t2;
        dd_q     <= diff * diff;
      end
      STEP_T2: b_q <= (dd_q >>> 12) * t3;
      STEP_T3: begin
        res_temp_o  <= t5_w[28:8];
        res_press_o <= '0;
        res_valid_o <= 1'b0;
      end
      STEP_P1: begin
        vv_q  <= v * v;
        vp5_q <= v * p5;
        vp2_q <= v * p2;
      end
      STEP_P2: begin
        vvp6_q <= vv_q * p6;
        vvp3_q <= vv_q * p3;
      end
      STEP_P3: begin
        e2_q  <= vvp6_q + (68'(vp5_q) <<< 17) + (68'(p4) <<< 35);
        acc_q <= (68'sd1 <<< 47) + (vvp3_q >>> 8) + (68'(vp2_q) <<< 12);
      end
      STEP_P4: begin
        div_q <= accp1[84:33];
        x_q   <= ((68'sd1048576 - 68'($signed({1'b0, adc_q}))) <<< 31) - e2_q;
      end
      STEP_P5: begin
        n_q   <= 76'(x_abs[63:0]) * 76'd3125;
        neg_q <= x_q[67] ^ div_q[51];
        dm_q  <= div_abs[DM_W-1:0];
      end
      STEP_ZERO: begin
        res_temp_o  <= '0;
        res_press_o <= '0;
        res_valid_o <= 1'b0;
      end
      STEP_DIV_INIT: begin
        sat_q <= {12'd0, n_hi} >= dm_q;
        rem_q <= {12'd0, n_hi};
        nq_q  <= n_q[QUOT_BITS-1:0];
      end
      STEP_DIV: begin
        rem_q <= qbit ? DM_W'(rem2 - {1'b0, dm_q}) : rem2[DM_W-1:0];
        nq_q  <= {nq_q[QUOT_BITS-2:0], qbit};
      end
      STEP_P7: begin
        if (neg_q) begin
          if (sat_q || nq_q > 40'h20_0000_0000) begin
            qs_q <= -(39'sd1 <<< 37);
          end else begin
            qs_q <= q_neg[38:0];
          end
        end else if (sat_q || nq_q > 40'h1F_FFFF_FFFF) begin
          qs_q <= (39'sd1 <<< 37) - 39'sd1;
        end else begin
          qs_q <= nq_q[38:0];
        end
      end
      STEP_P8: begin
        c9sq_q <= c9a * c9a;
        c8_q   <= qs_q * p8;
      end
      STEP_P9: c9_q <= c9p[68:25];
      STEP_P10: begin
        res_temp_o  <= '0;
        res_press_o <= pr_sat;
        res_valid_o <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status_o.div_zero = (div_q == '0);
  assign res_kind_o        = kind_q;

endmodule

`default_nettype wire

// ===== rtl/bpc_ctrl.sv =====
// Controller: sequences the datapath steps and the serial quotient loop.
// Depends on bpc_pkg; drives bpc_datapath through a command struct.
`default_nettype none

module bpc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_mode_i,
  output logic                      in_ready_o,
  input  wire bpc_pkg::dp_status_t  status_i,
  input  wire logic                 out_free_i,
  output bpc_pkg::ctrl_cmd_t        cmd_o
);
  import bpc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_T1, ST_T2, ST_T3, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
    ST_DIV_INIT, ST_DIV, ST_P7, ST_P8, ST_P9, ST_P10, ST_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= (in_mode_i == MODE_PRESS) ? ST_P1 : ST_T1;
          end
        end
        ST_T1:  state_q <= ST_T2;
        ST_T2:  state_q <= ST_T3;
        ST_T3:  state_q <= ST_DONE;
        ST_P1:  state_q <= ST_P2;
        ST_P2:  state_q <= ST_P3;
        ST_P3:  state_q <= ST_P4;
        ST_P4:  state_q <= ST_P5;
        ST_P5:  state_q <= status_i.div_zero ? ST_DONE : ST_DIV_INIT;
        ST_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(QUOT_BITS - 1)) begin
            state_q <= ST_P7;
          end
        end
        ST_P7:  state_q <= ST_P8;
        ST_P8:  state_q <= ST_P9;
        ST_P9:  state_q <= ST_P10;
        ST_P10: state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.out_load = (state_q == ST_DONE) && out_free_i;
    unique case (state_q)
      ST_IDLE:     cmd_o.step = in_valid_i ? STEP_LOAD : STEP_NONE;
      ST_T1:       cmd_o.step = STEP_T1;
      ST_T2:       cmd_o.step = STEP_T2;
      ST_T3:       cmd_o.step = STEP_T3;
      ST_P1:       cmd_o.step = STEP_P1;
      ST_P2:       cmd_o.step = STEP_P2;
      ST_P3:       cmd_o.step = STEP_P3;
      ST_P4:       cmd_o.step = STEP_P4;
      ST_P5:       cmd_o.step = status_i.div_zero ? STEP_ZERO : STEP_P5;
      ST_DIV_INIT: cmd_o.step = STEP_DIV_INIT;
      ST_DIV:      cmd_o.step = STEP_DIV;
      ST_P7:       cmd_o.step = STEP_P7;
      ST_P8:       cmd_o.step = STEP_P8;
      ST_P9:       cmd_o.step = STEP_P9;
      ST_P10:      cmd_o.step = STEP_P10;
      default:     cmd_o.step = STEP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/baro_temp_pressure_compensation.sv =====
// Top level: configuration registers, stream ports and output register.
// Depends on bpc_pkg, bpc_ctrl and bpc_datapath.
//
// Takes one raw sample per request and returns one result. A temperature
// request updates the stored fine temperature; a pressure request runs a
// serial quotient loop that yields one quotient bit per cycle, unless the
// divisor is zero, in which case no division is done.
// One request is in flight at a time; the next is accepted as soon as the
// previous result sits in the output register. Trim registers reset to zero
// and should be written only while the block is idle.
`default_nettype none

module baro_temp_pressure_compensation #(
  parameter int unsigned AdcBits = bpc_pkg::ADC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [19:0] raw_sample
  input  wire logic [bpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] mode
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [20:0] temperature_centi, [52:21] pressure_q24_8, [53] pressure_valid
  output logic [bpc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // [0] kind_echo
  output logic                                   m_axis_tuser,
  input  wire logic                              cfg_we_i,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bpc_pkg::CFG_W-1:0]         cfg_data_i
);
  import bpc_pkg::*;

  logic [CFG_W-1:0] temp_trim_q, press_low_q, press_mid_q, press_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q  <= '0;
      press_low_q  <= '0;
      press_mid_q  <= '0;
      press_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMP_TRIM:  temp_trim_q  <= cfg_data_i;
        CFG_PRESS_LOW:  press_low_q  <= cfg_data_i;
        CFG_PRESS_MID:  press_mid_q  <= cfg_data_i;
        CFG_PRESS_HIGH: press_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       out_free;
  logic       res_kind, res_valid;
  logic signed [TEMP_W-1:0] res_temp;
  logic [PRESS_W-1:0]       res_press;

  logic m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic m_user_q;

  assign out_free = !m_valid_q || m_axis_tready;

  bpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  bpc_datapath #(
    .AdcBits (AdcBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (cmd.step),
    .mode_i       (s_axis_tuser),
    .raw_i        (s_axis_tdata[RAW_W-1:0]),
    .temp_trim_i  (temp_trim_q),
    .press_low_i  (press_low_q),
    .press_mid_i  (press_mid_q),
    .press_high_i (press_high_q),
    .status_o     (status),
    .res_kind_o   (res_kind),
    .res_temp_o   (res_temp),
    .res_press_o  (res_press),
    .res_valid_o  (res_valid)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      m_data_q <= {2'b00, res_valid, res_press, res_temp};
      m_user_q <= res_kind;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result loaded over a pending one");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  a_temp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == MODE_TEMP) |->
      (m_axis_tdata[53:21] == '0))
    else $error("temperature result carries pressure bits");

  a_press_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == MODE_PRESS) |->
      (m_axis_tdata[20:0] == '0))
    else $error("pressure result carries temperature bits");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for baro_temp_pressure_compensation: directed table then random requests,
// checked against an in-bench compensation predictor. Depends on bpc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import bpc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  typedef struct {
    logic kind;
    logic [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0] press;
    logic pvalid;
  } comp_res_t;

  typedef struct {
    logic mode;
    logic [RAW_W-1:0] raw;
    logic chk;
    logic [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0] press;
    logic pvalid;
  } row_t;

  comp_res_t expected_q[$];
  logic [CFG_W-1:0] trim[4];
  logic signed [FINE_W-1:0] fine_t;
  int errors = 0;
  int rdy_gap = 0;
  bit quiet = 0;

  baro_temp_pressure_compensation dut (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("baro_temp_pressure_compensation test failed");
    $finish;
  end

  function automatic longint signed wd(logic [CFG_W-1:0] r, int k);
    return longint'($signed(r[16*k +: 16]));
  endfunction

  function automatic comp_res_t compensate(logic mode, logic [RAW_W-1:0] raw);
    comp_res_t r;
    longint signed adc, t1, t2, t3, a, d, b, tf;
    longint signed p1, v, e2, e1, acc, ah, al, dv, x, q, c9, c8, pr;
    logic signed [127:0] num, den, qw;
    r.kind = mode; r.temp = '0; r.press = '0; r.pvalid = 1'b0;
    adc = longint'(raw);
    if (mode == MODE_TEMP) begin
      t1 = longint'(trim[0][15:0]); t2 = wd(trim[0], 1); t3 = wd(trim[0], 2);
      a = (((adc >>> 3) - t1 * 2) * t2) >>> 11;
      d = (adc >>> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      tf = a + b;
      fine_t = tf[FINE_W-1:0];
      r.temp = 21'((tf * 5 + 128) >>> 8);
    end else begin
      p1 = longint'(trim[1][15:0]);
      v = longint'(fine_t) - 128000;
      e2 = v * v * wd(trim[2], 2) + v * wd(trim[2], 1) * 131072 + wd(trim[2], 0) * (64'sd1 <<< 35);
      e1 = ((v * v * wd(trim[1], 2)) >>> 8) + v * wd(trim[1], 1) * 4096;
      acc = (64'sd1 <<< 47) + e1;
      ah = acc >>> 17;
      al = acc - ah * 131072;
      dv = (ah * p1 + ((al * p1) >>> 17)) >>> 16;
      if (dv != 0) begin
        x = (1048576 - adc) * (64'sd1 <<< 31) - e2;
        num = 128'(x) * 128'sd3125;
        den = 128'(dv);
        qw = num / den;
        if (qw > 128'sd137438953471) q = 64'sd137438953471;
        else if (qw < -128'sd137438953472) q = -64'sd137438953472;
        else q = 64'(qw);
        c9 = q >>> 13;
        c9 = (wd(trim[3], 2) * (c9 * c9)) >>> 25;
        c8 = (wd(trim[3], 1) * q) >>> 19;
        pr = ((q + c9 + c8) >>> 8) + wd(trim[3], 0) * 16;
        if (pr < 0) pr = 0;
        if (pr > 64'sh0FFFFFFFF) pr = 64'sh0FFFFFFFF;
        r.press = pr[31:0];
        r.pvalid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic write_trim(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    trim[idx] = val;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic send(logic mode, logic [RAW_W-1:0] raw, comp_res_t forced, bit use_forced);
    comp_res_t e;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1; s_axis_tuser <= mode; s_axis_tdata <= {4'b0, raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    e = compensate(mode, raw);
    if (use_forced) e = forced;
    expected_q.push_back(e);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rdy_gap > 0) begin
      m_axis_tready <= 1'b0;
      rdy_gap <= rdy_gap - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rdy_gap <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    comp_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tuser !== e.kind || m_axis_tdata[20:0] !== e.temp ||
            m_axis_tdata[52:21] !== e.press || m_axis_tdata[53] !== e.pvalid) begin
          $display("%0t mismatch exp kind=%0d t=%h p=%h v=%0d act kind=%0d t=%h p=%h v=%0d",
                   $time, e.kind, e.temp, e.press, e.pvalid, m_axis_tuser,
                   m_axis_tdata[20:0], m_axis_tdata[52:21], m_axis_tdata[53]);
          errors++;
        end
      end
    end
  end

  localparam logic [CFG_W-1:0] TRIM_T = {16'hFF83, 16'h6A4D, 16'h6E6C};
  localparam logic [CFG_W-1:0] TRIM_PL = {16'h0BD0, 16'hD5DC, 16'h9476};
  localparam logic [CFG_W-1:0] TRIM_PM = {16'hFFF9, 16'h0092, 16'h1A9B};
  localparam logic [CFG_W-1:0] TRIM_PH = {16'h1770, 16'hC7F4, 16'h2710};

  row_t rows[] = '{
    '{MODE_TEMP,  20'h00000, 1'b1, 21'd0, 32'd0, 1'b0},
    '{MODE_PRESS, 20'h00000, 1'b1, 21'd0, 32'd0, 1'b0},
    '{MODE_PRESS, 20'hFFFFF, 1'b1, 21'd0, 32'd0, 1'b0},
    '{MODE_TEMP,  20'hFFFFF, 1'b1, 21'd0, 32'd0, 1'b0}
  };
  row_t rows2[] = '{
    '{MODE_TEMP,  20'h7EED0, 1'b0, '0, '0, 1'b0},
    '{MODE_PRESS, 20'h65A00, 1'b0, '0, '0, 1'b0},
    '{MODE_TEMP,  20'h00000, 1'b0, '0, '0, 1'b0},
    '{MODE_PRESS, 20'h00000, 1'b0, '0, '0, 1'b0},
    '{MODE_PRESS, 20'hFFFFF, 1'b0, '0, '0, 1'b0},
    '{MODE_TEMP,  20'hFFFFF, 1'b0, '0, '0, 1'b0},
    '{MODE_PRESS, 20'h80000, 1'b0, '0, '0, 1'b0},
    '{MODE_TEMP,  20'h55555, 1'b0, '0, '0, 1'b0},
    '{MODE_PRESS, 20'hAAAAA, 1'b0, '0, '0, 1'b0}
  };

  function automatic logic [CFG_W-1:0] rand_trim(int sel);
    logic [CFG_W-1:0] v;
    case (sel)
      0: v = '0;
      1: v = '1;
      2: v = {16'h7FFF, 16'h8000, 16'hFFFF};
      default: v = CFG_W'({$urandom(), $urandom()});
    endcase
    return v;
  endfunction

  initial begin
    comp_res_t f;
    int ph, i;
    fine_t = '0;
    foreach (trim[k]) trim[k] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[k]) begin
      f.kind = rows[k].mode; f.temp = rows[k].temp; f.press = rows[k].press;
      f.pvalid = rows[k].pvalid;
      send(rows[k].mode, rows[k].raw, f, rows[k].chk);
    end
    drain();
    write_trim(CFG_TEMP_TRIM, TRIM_T);
    write_trim(CFG_PRESS_LOW, TRIM_PL);
    write_trim(CFG_PRESS_MID, TRIM_PM);
    write_trim(CFG_PRESS_HIGH, TRIM_PH);
    foreach (rows2[k]) send(rows2[k].mode, rows2[k].raw, f, 1'b0);
    drain();
    for (ph = 0; ph < 17; ph++) begin
      if (ph == 16) quiet = 1;
      if (ph < 3) begin
        for (i = 0; i < 4; i++) write_trim(CFG_IDX_W'(i), rand_trim(ph));
      end else if (ph < 10) begin
        write_trim(CFG_TEMP_TRIM, TRIM_T ^ CFG_W'($urandom_range(0, 255)));
        write_trim(CFG_PRESS_LOW, TRIM_PL ^ CFG_W'($urandom_range(0, 255)));
        write_trim(CFG_PRESS_MID, TRIM_PM ^ CFG_W'($urandom_range(0, 255)));
        write_trim(CFG_PRESS_HIGH, TRIM_PH ^ CFG_W'($urandom_range(0, 255)));
      end else begin
        for (i = 0; i < 4; i++) write_trim(CFG_IDX_W'(i), rand_trim(3));
      end
      for (i = 0; i < 100; i++) begin
        send(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ?
             RAW_W'($urandom) : RAW_W'($urandom_range(20'h40000, 20'h90000)), f, 1'b0);
        if (i == 50 && ph == 5) drain();
      end
      drain();
    end
    if (errors == 0) $display("baro_temp_pressure_compensation test passed");
    else $display("baro_temp_pressure_compensation test failed");
    $finish;
  end
endmodule
